[rtl/core/fmh_pkg.sv]
// Package for the FIFO mutex: request and response types, codes and defaults.
package fmh_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int TID_W           = 6;
  localparam int WAIT_CNT_W      = 7;

  typedef enum logic [1:0] {
    KIND_INIT    = 2'd0,
    KIND_LOCK    = 2'd1,
    KIND_TRYLOCK = 2'd2,
    KIND_UNLOCK  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_BUSY      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_HANDOFF   = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6,
    ST_CLEARED   = 3'd7
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [TID_W-1:0]   thread_id;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic                   woken_valid;
    logic [TID_W-1:0]       woken_thread;
    logic                   owner_valid;
    logic [TID_W-1:0]       owner_thread;
    logic [WAIT_CNT_W-1:0]  waiting_count;
  } rsp_t;

endpackage

[rtl/core/fifo_mutex_handoff.sv]
// FIFO mutex with direct handoff: lock state, wait queue control and response register.
//
// Requests arrive on req (valid/ready) as a kind and a thread id; every request
// yields exactly one response on rsp (valid/ready) carrying the status, the
// thread woken by handoff, the owner after the request and the waiter count.
// Waiting thread ids live in a synchronous RAM of QUEUE_DEPTH entries; the
// owner, head, tail and count sit in flops.
// On the transfer cycle a request starts a read of the queue head; in S_EXEC
// that read data is used to commit the update and load the response register,
// once the response register is free. Because of the registered RAM read, the
// block does not take a new request until the current one has committed.
// The response is registered: rsp_valid rises after the request commits in S_EXEC.
// A new request is taken while the previous response still waits in the
// output register; if the receiver stalls, the following request holds in
// its commit cycle until the response register frees, and req_ready stays low.
// Reset (rst, synchronous) frees the lock, empties the queue and drops any
// pending response; the RAM needs no clearing pass.
module fifo_mutex_handoff
  import fmh_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t            state;
  req_t              req_q;
  logic              held, held_next;
  logic [TID_W-1:0]  holder, holder_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [CW-1:0]     count, count_next;
  rsp_t              rsp_next;

  logic              accept;
  logic              slot_free;
  logic              commit;
  logic              push;
  logic [TID_W-1:0]  head_tid;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign commit    = (state == S_EXEC) && slot_free;

  fmh_ram #(
    .WIDTH (TID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail),
    .wr_data (req_q.thread_id),
    .rd_en   (accept),
    .rd_addr (head),
    .rd_data (head_tid)
  );

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
    return (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    held_next            = held;
    holder_next          = holder;
    head_next            = head;
    tail_next            = tail;
    count_next           = count;
    push                 = 1'b0;
    rsp_next.status      = ST_CLEARED;
    rsp_next.woken_valid = 1'b0;
    rsp_next.woken_thread = '0;
    case (req_q.kind)
      KIND_INIT: begin
        held_next   = 1'b0;
        holder_next = '0;
        head_next   = '0;
        tail_next   = '0;
        count_next  = '0;
      end
      KIND_LOCK: begin
        if (!held) begin
          held_next       = 1'b1;
          holder_next     = req_q.thread_id;
          rsp_next.status = ST_GRANTED;
        end else if (count == CW'(QUEUE_DEPTH)) begin
          rsp_next.status = ST_FULL;
        end else begin
          push            = commit;
          tail_next       = advance(tail);
          count_next      = count + 1'b1;
          rsp_next.status = ST_QUEUED;
        end
      end
      KIND_TRYLOCK: begin
        if (!held) begin
          held_next       = 1'b1;
          holder_next     = req_q.thread_id;
          rsp_next.status = ST_GRANTED;
        end else begin
          rsp_next.status = ST_BUSY;
        end
      end
      KIND_UNLOCK: begin
        if (!held || holder != req_q.thread_id) begin
          rsp_next.status = ST_NOT_OWNER;
        end else if (count != '0) begin
          head_next             = advance(head);
          count_next            = count - 1'b1;
          holder_next           = head_tid;
          rsp_next.woken_valid  = 1'b1;
          rsp_next.woken_thread = head_tid;
          rsp_next.status       = ST_HANDOFF;
        end else begin
          held_next       = 1'b0;
          holder_next     = '0;
          rsp_next.status = ST_RELEASED;
        end
      end
      default: begin
        rsp_next.status = ST_CLEARED;
      end
    endcase
    rsp_next.owner_valid   = held_next;
    rsp_next.owner_thread  = held_next ? holder_next : '0;
    rsp_next.waiting_count = WAIT_CNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      state     <= S_IDLE;
      held      <= 1'b0;
      holder    <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        held   <= held_next;
        holder <= holder_next;
        head   <= head_next;
        tail   <= tail_next;
        count  <= count_next;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/fmh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/fmh_checker.sv]
// Port-level checker for the FIFO mutex, bound to the top level.
module fmh_checker
  import fmh_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_woken_handoff: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.woken_valid == (rsp.status == ST_HANDOFF)))
    else $error("woken flag disagrees with handoff status");

  a_free_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.owner_valid |-> rsp.owner_thread == '0 && rsp.woken_thread == '0)
    else $error("free lock reports an owner or woken thread");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_CLEARED |-> !rsp.owner_valid && rsp.waiting_count == '0)
    else $error("cleared response shows remaining state");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind fifo_mutex_handoff fmh_checker u_fmh_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
